>>> rtl/core/assert_macros.svh
// Assertion macros used by the GF(2^128) multiplier top level.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/gf128m_pkg.sv
// Package for the GF(2^128) multiplier: widths, datapath types and the
// 32x32 carry-less product function. No dependencies.
`timescale 1ns / 1ps
package gf128m_pkg;

  localparam int unsigned HALF_W      = 64;
  localparam int unsigned FIELD_W     = 128;
  localparam int unsigned PROD_W      = 255;
  localparam int unsigned SLICE_W     = 32;
  localparam int unsigned NUM_SLICES  = FIELD_W / SLICE_W;
  localparam int unsigned PP_W        = 2 * SLICE_W - 1;
  localparam int unsigned NUM_PP      = NUM_SLICES * NUM_SLICES;
  // x^7 is the highest tap below x^128, so one fold spills 6 bits at most
  localparam int unsigned TAP_A       = 1;
  localparam int unsigned TAP_B       = 2;
  localparam int unsigned TAP_C       = 7;
  localparam int unsigned FOLD_W      = PROD_W - FIELD_W + TAP_C;
  localparam int unsigned IN_TDATA_W  = 4 * HALF_W;
  localparam int unsigned OUT_TDATA_W = 2 * HALF_W;

  typedef logic [PP_W-1:0]    pp_t;
  typedef pp_t [NUM_PP-1:0]   pp_arr_t;
  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [FOLD_W-1:0]  fold_t;

  // Per-stage load enables, driven by the top-level flow control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

  // 32x32 carry-less product, 63 bits
  function automatic pp_t clmul32(input logic [SLICE_W-1:0] a,
                                  input logic [SLICE_W-1:0] b);
    pp_t acc;
    acc = '0;
    for (int j = 0; j < SLICE_W; j++) begin
      if (b[j]) begin
        acc = acc ^ (pp_t'(a) << j);
      end
    end
    return acc;
  endfunction

endpackage

>>> rtl/core/gf128_multiplier.sv
// Top level of the GF(2^128) multiplier: stream ports, stage valids and
// flow control. Depends on gf128m_pkg, gf128m_pp_gen, gf128m_accum,
// gf128m_reduce and assert_macros.svh.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------
//  in_     | in  | in_tvalid/tready  | x_upper, x_lower, y_upper, y_lower
//  out_    | out | out_tvalid/tready | prod_upper, prod_lower
//
// One transaction per cycle sustained while out_tready is high; the four
// register stages are partial products, merge, first fold and second fold.
// rst_n clears the stage valid bits only; the datapath registers are not reset.
// Each stage loads when it is empty or the stage after it loads, so a stall
// at the output holds the full stages in front of it and bubbles are squeezed out.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gf128_multiplier (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // x_upper [63:0], x_lower [127:64], y_upper [191:128], y_lower [255:192]
  input  logic [gf128m_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // prod_upper [63:0], prod_lower [127:64]
  output logic [gf128m_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import gf128m_pkg::*;

  logic     s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic     s1_vld_nxt, s2_vld_nxt, s3_vld_nxt, s4_vld_nxt;
  pipe_en_t en;
  field_t   x_op, y_op;
  pp_arr_t  pp;
  prod_t    prod;
  field_t   res;

  // a stage may load if empty or if its content moves on this cycle
  assign en.s4 = !s4_vld_r || out_tready;
  assign en.s3 = !s3_vld_r || en.s4;
  assign en.s2 = !s2_vld_r || en.s3;
  assign en.s1 = !s1_vld_r || en.s2;

  assign in_tready = en.s1;

  always_comb begin
    s1_vld_nxt = en.s1 ? in_tvalid : s1_vld_r;
    s2_vld_nxt = en.s2 ? s1_vld_r  : s2_vld_r;
    s3_vld_nxt = en.s3 ? s2_vld_r  : s3_vld_r;
    s4_vld_nxt = en.s4 ? s3_vld_r  : s4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      s3_vld_r <= s3_vld_nxt;
      s4_vld_r <= s4_vld_nxt;
    end
  end

  // operand unpacking: upper half holds x^127..x^64
  assign x_op = {in_tdata[HALF_W-1:0],          in_tdata[2*HALF_W-1:HALF_W]};
  assign y_op = {in_tdata[3*HALF_W-1:2*HALF_W], in_tdata[4*HALF_W-1:3*HALF_W]};

  gf128m_pp_gen u_pp_gen (
    .clk (clk),
    .en  (en),
    .x   (x_op),
    .y   (y_op),
    .pp  (pp)
  );

  gf128m_accum u_accum (
    .clk  (clk),
    .en   (en),
    .pp   (pp),
    .prod (prod)
  );

  gf128m_reduce u_reduce (
    .clk  (clk),
    .en   (en),
    .prod (prod),
    .res  (res)
  );

  assign out_tvalid = s4_vld_r;
  assign out_tdata  = {res[HALF_W-1:0], res[FIELD_W-1:HALF_W]};

  // pipeline occupancy checks
  `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_tvalid && in_tready, s1_vld_r, "accepted transaction not in stage 1")
  `ASSERT_NEXT(a_s2_moves_on, clk, rst_n, s2_vld_r && en.s3, s3_vld_r, "stage 2 item lost on advance")
  `ASSERT_NEXT(a_s3_holds, clk, rst_n, s3_vld_r && !en.s3, s3_vld_r, "stalled stage 3 item dropped")
  `ASSERT_IMPL(a_full_blocks, clk, rst_n, s1_vld_r && s2_vld_r && s3_vld_r && s4_vld_r && !out_tready, !in_tready, "input taken while pipeline full")

endmodule

>>> rtl/core/gf128m_pp_gen.sv
// Stage 1: sixteen 32x32 carry-less partial products of the operands.
// Depends on gf128m_pkg.
`timescale 1ns / 1ps
module gf128m_pp_gen (
  input  logic                clk,
  input  gf128m_pkg::pipe_en_t en,
  input  gf128m_pkg::field_t  x,
  input  gf128m_pkg::field_t  y,
  output gf128m_pkg::pp_arr_t pp
);
  import gf128m_pkg::*;

  pp_arr_t pp_nxt;
  pp_arr_t pp_r;

  // one product per pair of 32-bit slices
  always_comb begin
    for (int i = 0; i < NUM_SLICES; i++) begin
      for (int j = 0; j < NUM_SLICES; j++) begin
        pp_nxt[i*NUM_SLICES + j] = clmul32(x[i*SLICE_W +: SLICE_W],
                                           y[j*SLICE_W +: SLICE_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      pp_r <= pp_nxt;
    end
  end

  assign pp = pp_r;

endmodule

>>> rtl/core/gf128m_accum.sv
// Stage 2: merges the partial products into the 255-bit carry-less product.
// Depends on gf128m_pkg.
`timescale 1ns / 1ps
module gf128m_accum (
  input  logic                clk,
  input  gf128m_pkg::pipe_en_t en,
  input  gf128m_pkg::pp_arr_t pp,
  output gf128m_pkg::prod_t   prod
);
  import gf128m_pkg::*;

  prod_t prod_nxt;
  prod_t prod_r;

  // slice pair (i, j) sits at bit 32*(i+j); at most seven terms per bit
  always_comb begin
    prod_nxt = '0;
    for (int i = 0; i < NUM_SLICES; i++) begin
      for (int j = 0; j < NUM_SLICES; j++) begin
        prod_nxt = prod_nxt ^ (prod_t'(pp[i*NUM_SLICES + j]) << (SLICE_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

>>> rtl/core/gf128m_reduce.sv
// Stages 3 and 4: reduction modulo x^128 + x^7 + x^2 + x + 1 in two folds.
// Depends on gf128m_pkg.
`timescale 1ns / 1ps
module gf128m_reduce (
  input  logic                clk,
  input  gf128m_pkg::pipe_en_t en,
  input  gf128m_pkg::prod_t   prod,
  output gf128m_pkg::field_t  res
);
  import gf128m_pkg::*;

  localparam int unsigned HI_W    = PROD_W - FIELD_W;
  localparam int unsigned SPILL_W = FOLD_W - FIELD_W;

  logic [HI_W-1:0]    hi;
  logic [SPILL_W-1:0] spill;
  fold_t              fold_nxt;
  fold_t              fold_r;
  field_t             res_nxt;
  field_t             res_r;

  // first fold: H*x^128 == H*(x^7 + x^2 + x + 1), may spill above x^127
  assign hi = prod[PROD_W-1:FIELD_W];

  always_comb begin
    fold_nxt = fold_t'(prod[FIELD_W-1:0]) ^ fold_t'(hi)
             ^ (fold_t'(hi) << TAP_A) ^ (fold_t'(hi) << TAP_B)
             ^ (fold_t'(hi) << TAP_C);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      fold_r <= fold_nxt;
    end
  end

  // second fold: the spill is short, its image stays below x^128
  assign spill = fold_r[FOLD_W-1:FIELD_W];

  always_comb begin
    res_nxt = fold_r[FIELD_W-1:0] ^ field_t'(spill)
            ^ (field_t'(spill) << TAP_A) ^ (field_t'(spill) << TAP_B)
            ^ (field_t'(spill) << TAP_C);
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

>>> test/tb_gf128_multiplier.sv
// Testbench for gf128_multiplier: GF(2^128) products checked against a local
// bit-serial multiply and reduce, under random stalls on both stream sides.
// Depends on gf128m_pkg and the gf128_multiplier RTL.
`timescale 1ns / 1ps
module tb_gf128_multiplier;
  import gf128m_pkg::*;

  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned HOLD_LEN   = 120;
  localparam int unsigned HOLD_AT    = 300;
  localparam int unsigned RAND_ITEMS = 1600;

  typedef struct packed {
    logic [HALF_W-1:0] prod_upper;
    logic [HALF_W-1:0] prod_lower;
  } product_t;

  // Expected field products, oldest first, plus the multiply that makes them
  class field_product_board;
    product_t pending_products[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // Carry-less multiply, then fold x^(128+i) into x^i, x^(i+1), x^(i+2), x^(i+7)
    function logic [FIELD_W-1:0] field_mul(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
      logic [2*FIELD_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < FIELD_W; i++) begin
        if (b[i]) acc = acc ^ ({{FIELD_W{1'b0}}, a} << i);
      end
      // descending order: high spill of a fold lands on a bit still to come
      for (int i = FIELD_W - 1; i >= 0; i--) begin
        if (acc[FIELD_W+i]) begin
          acc[FIELD_W+i] = 1'b0;
          acc[i]   = ~acc[i];
          acc[i+1] = ~acc[i+1];
          acc[i+2] = ~acc[i+2];
          acc[i+7] = ~acc[i+7];
        end
      end
      return acc[FIELD_W-1:0];
    endfunction

    function void note_operands(logic [HALF_W-1:0] xu, logic [HALF_W-1:0] xl,
                                logic [HALF_W-1:0] yu, logic [HALF_W-1:0] yl);
      logic [FIELD_W-1:0] prod;
      prod = field_mul({xu, xl}, {yu, yl});
      pending_products.push_back('{prod_upper: prod[FIELD_W-1:HALF_W],
                                   prod_lower: prod[HALF_W-1:0]});
    endfunction

    function void check_product(logic [HALF_W-1:0] pu, logic [HALF_W-1:0] pl);
      product_t want;
      if (pending_products.size() == 0) begin
        $error("product %h_%h arrived with none outstanding", pu, pl);
        errors++;
        return;
      end
      want = pending_products.pop_front();
      if (pu !== want.prod_upper) begin
        $error("prod_upper: expected %h, got %h", want.prod_upper, pu);
        errors++;
      end
      if (pl !== want.prod_lower) begin
        $error("prod_lower: expected %h, got %h", want.prod_lower, pl);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // x_upper [63:0], x_lower [127:64], y_upper [191:128], y_lower [255:192]
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // prod_upper [63:0], prod_lower [127:64]
  logic [OUT_TDATA_W-1:0] out_tdata;

  field_product_board board = new();

  int idle_cycles  = 0;

  gf128_multiplier u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Gap before the next transaction: runs of no idling mix with runs of random gaps
  function automatic int draw_gap(ref int burst_left, ref bit quiet);
    if (burst_left == 0) begin
      burst_left = $urandom_range(20, 80);
      quiet      = ($urandom_range(0, 2) == 0);
    end
    burst_left--;
    return quiet ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [HALF_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Transaction monitors, sampled at the edge before any drive update lands
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      board.note_operands(in_tdata[63:0], in_tdata[127:64],
                          in_tdata[191:128], in_tdata[255:192]);
    if (rst_n && out_tvalid && out_tready)
      board.check_product(out_tdata[63:0], out_tdata[127:64]);
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("gf128_multiplier: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, one long hold-off after a fixed result count
  initial begin
    int gap;
    int burst_left;
    bit quiet;
    int taken;
    burst_left = 0;
    quiet      = 1'b0;
    taken      = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(burst_left, quiet);
      if (taken == HOLD_AT) gap = HOLD_LEN;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
    end
  end

  int tx_burst_left = 0;
  bit tx_quiet      = 1'b0;

  task automatic send_operands(input logic [HALF_W-1:0] xu, input logic [HALF_W-1:0] xl,
                               input logic [HALF_W-1:0] yu, input logic [HALF_W-1:0] yl);
    int gap;
    gap = draw_gap(tx_burst_left, tx_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {yl, yu, xl, xu};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_field(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y);
    send_operands(x[FIELD_W-1:HALF_W], x[HALF_W-1:0], y[FIELD_W-1:HALF_W], y[HALF_W-1:0]);
  endtask

  initial begin
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
    logic [FIELD_W-1:0] ones;
    logic [FIELD_W-1:0] top;
    ones = '1;
    top  = {1'b1, {(FIELD_W-1){1'b0}}};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero operands, identity, field extremes, high fold terms
    send_field('0, '0);
    send_field('0, {rand64(), rand64()});
    send_field({rand64(), rand64()}, '0);
    send_field(128'd1, {rand64(), rand64()});
    send_field({rand64(), rand64()}, 128'd1);
    send_field(ones, ones);
    send_field(top, top);
    send_field(top, 128'd2);
    send_field(top, 128'h80);
    send_field(top, ones);
    send_field(128'd1 << HALF_W, 128'd1 << HALF_W);
    send_field({{HALF_W{1'b1}}, {HALF_W{1'b0}}}, {{HALF_W{1'b1}}, {HALF_W{1'b0}}});
    send_field({{HALF_W{1'b0}}, {HALF_W{1'b1}}}, {{HALF_W{1'b0}}, {HALF_W{1'b1}}});
    send_field({{HALF_W{1'b1}}, {HALF_W{1'b0}}}, {{HALF_W{1'b0}}, {HALF_W{1'b1}}});
    send_field(128'hFE << 120, 128'hFE << 120);
    send_field(ones, 128'd1);

    // Random: mostly dense operands, with sparse and high-heavy mixes
    for (int n = 0; n < RAND_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        6: begin
          x = 128'd1 << $urandom_range(0, FIELD_W - 1);
          y = 128'd1 << $urandom_range(0, FIELD_W - 1);
        end
        7: begin
          x = {rand64(), {HALF_W{1'b0}}};
          y = {rand64(), {HALF_W{1'b0}}};
        end
        8: begin
          x = {rand64(), rand64()};
          y = FIELD_W'($urandom_range(0, 1));
        end
        9: begin
          x = ones;
          y = {rand64(), rand64()};
        end
        default: begin
          x = {rand64(), rand64()};
          y = {rand64(), rand64()};
        end
      endcase
      if ($urandom_range(0, 1) == 1) send_field(x, y);
      else send_field(y, x);
    end
    in_tvalid <= 1'b0;
    // let the monitor log the last accepted transaction first
    @(posedge clk);

    // Drain, then allow the pipeline depth for anything stray
    while (board.pending_products.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending_products.size() == 0) begin
      $display("gf128_multiplier: match");
    end else begin
      $display("gf128_multiplier: mismatch");
    end
    $finish;
  end

endmodule
